>>> rtl/pdu_pkg.sv
`default_nettype none

package pdu_pkg;

  // Geometry defaults of the display
  localparam int WINDOWS_PER_ROW_DEF = 16;
  localparam int WINDOW_ROWS_DEF     = 13;
  localparam int WINDOW_WIDTH_DEF    = 2;
  localparam int WINDOW_HEIGHT_DEF   = 2;

  // Field widths
  localparam int POS_W   = 17;  // linear pixel position, protocol 2
  localparam int WIN_W   = 15;  // absolute window number, protocol 1
  localparam int WROW_W  = 3;
  localparam int WCOL_W  = 3;
  localparam int ADDR_W  = 10;
  localparam int CFG_W   = 10;
  localparam int CFG_IDX_W = 3;

  // Stages between the input port and the result port
  localparam int PIPE_DEPTH = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED_COLOR       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_NIBBLE_SHIFT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_LIMIT       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_PACKET  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOWS_PER_PACKET = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_COUNT       = 3'd6;

  // Configuration reset values
  localparam logic       PACKED_COLOR_RST       = 1'b1;
  localparam logic [2:0] LOW_NIBBLE_SHIFT_RST   = 3'd4;
  localparam logic [3:0] HEADER_BYTES_RST       = 4'd2;
  localparam logic [7:0] PACKET_LIMIT_RST       = 8'd1;
  localparam logic [9:0] PIXELS_PER_PACKET_RST  = 10'd832;
  localparam logic [7:0] WINDOWS_PER_PACKET_RST = 8'd208;
  localparam logic [7:0] WINDOW_COUNT_RST       = 8'd208;

  // Header protocol codes
  localparam logic [7:0] PROTO_WINDOWED = 8'd1;
  localparam logic [7:0] PROTO_LINEAR   = 8'd2;

  localparam logic [7:0] HI_NIBBLE_MASK = 8'hf0;
  localparam logic [7:0] LO_NIBBLE_MASK = 8'h0f;

  typedef enum logic [1:0] {
    ST_NONE      = 2'd0,
    ST_READY     = 2'd1,
    ST_HDR_ERROR = 2'd2,
    ST_SHORT     = 2'd3
  } status_t;

  typedef struct packed {
    logic       packed_color;
    logic [2:0] low_nibble_shift;
    logic [3:0] header_bytes;
    logic [7:0] packet_limit;
    logic [9:0] pixels_per_packet;
    logic [7:0] windows_per_packet;
    logic [7:0] window_count;
  } cfg_t;

  // One parsed byte on its way to address generation
  typedef struct packed {
    logic              have;    // a complete pixel came with this byte
    logic              linear;  // protocol 2 addressing
    logic [POS_W-1:0]  pos;     // linear position, or window number in the low bits
    logic [WROW_W-1:0] wrow;
    logic [WCOL_W-1:0] wcol;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    status_t           status;
  } pix_item_t;

endpackage

`default_nettype wire

>>> rtl/pdu_parser.sv
`default_nettype none

module pdu_parser #(
  parameter int WINDOW_WIDTH  = pdu_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = pdu_pkg::WINDOW_HEIGHT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pdu_pkg::cfg_t     cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_last,
  output logic                   item_valid,
  input  wire logic              item_ready,
  output pdu_pkg::pix_item_t     item
);

  localparam int WROW_W_L = pdu_pkg::WROW_W;
  localparam int WCOL_W_L = pdu_pkg::WCOL_W;

  typedef enum logic [1:0] {
    MODE_HEADER,
    MODE_DATA,
    MODE_DRAIN
  } mode_t;

  mode_t       mode, mode_next;
  logic [3:0]  header_count, header_count_next;
  logic [6:0]  packet_index, packet_index_next;
  logic        protocol_two, protocol_two_next;
  logic [9:0]  pixel_count, pixel_count_next;
  logic [7:0]  window_index, window_index_next;
  logic [WROW_W_L-1:0] window_row, window_row_next;
  logic [WCOL_W_L-1:0] window_column, window_column_next;
  logic [1:0]  byte_phase, byte_phase_next;
  logic [7:0]  held_byte, held_byte_next;
  logic [7:0]  held_second, held_second_next;

  pdu_pkg::pix_item_t item_next;

  logic        accept;
  logic [3:0]  hdr_len;
  logic [3:0]  hc_inc;
  logic        bad;
  logic [6:0]  idx_sel;
  logic [9:0]  mcand;
  logic [16:0] prod;
  logic        work_empty;
  logic [16:0] pos_linear;
  logic [16:0] pos_window;
  logic        odd;
  logic        done;
  logic [8:0]  wi_inc;
  logic [16:0] win_reach;

  function automatic logic [7:0] hi_nib(input logic [7:0] v);
    hi_nib = v & pdu_pkg::HI_NIBBLE_MASK;
  endfunction

  function automatic logic [7:0] lo_nib(input logic [7:0] v, input logic [2:0] s);
    lo_nib = (v & pdu_pkg::LO_NIBBLE_MASK) << s;
  endfunction

  assign accept   = in_valid && in_ready;
  assign in_ready = !item_valid || item_ready;

  assign hdr_len = (cfg.header_bytes < 4'd2) ? 4'd2 : cfg.header_bytes;
  assign hc_inc  = (header_count == 4'd15) ? header_count : header_count + 4'd1;

  // The index byte is needed in the same cycle when the header ends on it
  assign idx_sel = (mode == MODE_HEADER && header_count == 4'd1) ? in_byte[6:0] : packet_index;
  assign mcand   = protocol_two ? cfg.pixels_per_packet : {2'b00, cfg.windows_per_packet};
  assign prod    = 17'(idx_sel) * 17'(mcand);

  assign work_empty = protocol_two ? (cfg.pixels_per_packet == 10'd0)
                    : (cfg.windows_per_packet == 8'd0 || prod >= 17'(cfg.window_count));

  assign pos_linear = prod + 17'(pixel_count);
  assign pos_window = prod + 17'(window_index);
  assign odd        = protocol_two ? pos_linear[0] : window_column[0];

  always_comb begin
    mode_next          = mode;
    header_count_next  = header_count;
    packet_index_next  = packet_index;
    protocol_two_next  = protocol_two;
    pixel_count_next   = pixel_count;
    window_index_next  = window_index;
    window_row_next    = window_row;
    window_column_next = window_column;
    byte_phase_next    = byte_phase;
    held_byte_next     = held_byte;
    held_second_next   = held_second;
    bad                = 1'b0;
    done               = 1'b0;
    wi_inc             = 9'(window_index);
    win_reach          = '0;
    item_next.have     = 1'b0;
    item_next.linear   = protocol_two;
    item_next.pos      = protocol_two ? pos_linear : pos_window;
    item_next.wrow     = window_row;
    item_next.wcol     = window_column;
    item_next.red      = 8'd0;
    item_next.green    = 8'd0;
    item_next.blue     = 8'd0;
    item_next.status   = pdu_pkg::ST_NONE;

    case (mode)
      MODE_HEADER: begin
        if (header_count == 4'd0) begin
          if (in_byte != pdu_pkg::PROTO_WINDOWED && in_byte != pdu_pkg::PROTO_LINEAR) begin
            bad = 1'b1;
          end else begin
            protocol_two_next = (in_byte == pdu_pkg::PROTO_LINEAR);
          end
        end else if (header_count == 4'd1) begin
          if (in_byte[7] || in_byte >= cfg.packet_limit) begin
            bad = 1'b1;
          end else begin
            packet_index_next = in_byte[6:0];
          end
        end
        if (bad) begin
          item_next.status = pdu_pkg::ST_HDR_ERROR;
          mode_next        = MODE_DRAIN;
        end else begin
          header_count_next = hc_inc;
          if (hc_inc >= hdr_len) begin
            pixel_count_next   = '0;
            window_index_next  = '0;
            window_row_next    = '0;
            window_column_next = '0;
            byte_phase_next    = '0;
            if (work_empty) begin
              item_next.status = pdu_pkg::ST_READY;
              mode_next        = MODE_DRAIN;
            end else begin
              mode_next = MODE_DATA;
            end
          end else if (in_last) begin
            item_next.status = (hc_inc >= 4'd2 && work_empty) ? pdu_pkg::ST_READY
                                                              : pdu_pkg::ST_SHORT;
          end
        end
      end

      MODE_DATA: begin
        if (cfg.packed_color) begin
          if (byte_phase == 2'd0) begin
            held_byte_next  = in_byte;
            byte_phase_next = 2'd1;
          end else begin
            if (odd) begin
              item_next.red   = lo_nib(held_byte, cfg.low_nibble_shift);
              item_next.green = hi_nib(in_byte);
              item_next.blue  = lo_nib(in_byte, cfg.low_nibble_shift);
              byte_phase_next = 2'd0;
            end else begin
              item_next.red   = hi_nib(held_byte);
              item_next.green = lo_nib(held_byte, cfg.low_nibble_shift);
              item_next.blue  = hi_nib(in_byte);
              held_byte_next  = in_byte;
              byte_phase_next = 2'd1;
            end
            item_next.have = 1'b1;
          end
        end else begin
          case (byte_phase)
            2'd0: begin
              held_byte_next  = in_byte;
              byte_phase_next = 2'd1;
            end
            2'd1: begin
              held_second_next = in_byte;
              byte_phase_next  = 2'd2;
            end
            default: begin
              item_next.red   = held_byte;
              item_next.green = held_second;
              item_next.blue  = in_byte;
              byte_phase_next = 2'd0;
              item_next.have  = 1'b1;
            end
          endcase
        end

        if (item_next.have) begin
          if (protocol_two) begin
            pixel_count_next = pixel_count + 10'd1;
            done = (11'(pixel_count) + 11'd1) >= 11'(cfg.pixels_per_packet);
          end else begin
            // Advance column, then row, then window
            if (4'(window_column) + 4'd1 >= 4'(WINDOW_WIDTH)) begin
              window_column_next = '0;
              if (4'(window_row) + 4'd1 >= 4'(WINDOW_HEIGHT)) begin
                window_row_next = '0;
                wi_inc          = 9'(window_index) + 9'd1;
              end else begin
                window_row_next = window_row + WROW_W_L'(1);
              end
            end else begin
              window_column_next = window_column + WCOL_W_L'(1);
            end
            window_index_next = wi_inc[7:0];
            win_reach = prod + 17'(wi_inc);
            done = (wi_inc >= 9'(cfg.windows_per_packet))
                || (win_reach >= 17'(cfg.window_count));
          end
          if (done) begin
            item_next.status = pdu_pkg::ST_READY;
            mode_next        = MODE_DRAIN;
          end
        end
        if (in_last && mode_next == MODE_DATA) begin
          item_next.status = pdu_pkg::ST_SHORT;
        end
      end

      default: begin
      end
    endcase

    if (in_last) begin
      mode_next         = MODE_HEADER;
      header_count_next = '0;
      byte_phase_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_HEADER;
      header_count  <= '0;
      packet_index  <= '0;
      protocol_two  <= 1'b0;
      pixel_count   <= '0;
      window_index  <= '0;
      window_row    <= '0;
      window_column <= '0;
      byte_phase    <= '0;
      held_byte     <= '0;
      held_second   <= '0;
      item_valid    <= 1'b0;
    end else if (accept) begin
      mode          <= mode_next;
      header_count  <= header_count_next;
      packet_index  <= packet_index_next;
      protocol_two  <= protocol_two_next;
      pixel_count   <= pixel_count_next;
      window_index  <= window_index_next;
      window_row    <= window_row_next;
      window_column <= window_column_next;
      byte_phase    <= byte_phase_next;
      held_byte     <= held_byte_next;
      held_second   <= held_second_next;
      item_valid    <= 1'b1;
    end else if (item_ready) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pdu_addr.sv
`default_nettype none

module pdu_addr #(
  parameter int WINDOWS_PER_ROW = pdu_pkg::WINDOWS_PER_ROW_DEF,
  parameter int WINDOW_ROWS     = pdu_pkg::WINDOW_ROWS_DEF,
  parameter int WINDOW_WIDTH    = pdu_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT   = pdu_pkg::WINDOW_HEIGHT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          item_valid,
  output logic                               item_ready,
  input  wire pdu_pkg::pix_item_t            item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_we,
  output logic [pdu_pkg::ADDR_W-1:0]         out_addr,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output pdu_pkg::status_t                   out_status
);

  localparam int WIN_W       = pdu_pkg::WIN_W;
  localparam int ADDR_W      = pdu_pkg::ADDR_W;
  localparam int FRAME_COLS  = WINDOWS_PER_ROW * WINDOW_WIDTH;
  localparam int FRAME_ROWS  = WINDOW_ROWS * WINDOW_HEIGHT;
  localparam int FRAME_PIXELS = FRAME_COLS * FRAME_ROWS;
  // Window number divided by windows per row through a reciprocal, exact for WIN_W bits
  localparam int DIV_SHIFT   = WIN_W + $clog2(WINDOWS_PER_ROW) + 1;
  localparam int RECIP       = ((2 ** DIV_SHIFT) + WINDOWS_PER_ROW - 1) / WINDOWS_PER_ROW;
  localparam int RECIP_W     = DIV_SHIFT + 1;
  localparam int PROD_W      = WIN_W + RECIP_W;
  localparam int REM_W       = $clog2(WINDOWS_PER_ROW) + 1;
  localparam int ROW_W       = WIN_W + 4;
  localparam int COL_W       = REM_W + 4;

  logic ready2, ready3, ready4, ready5;
  logic v2, v3, v4;

  pdu_pkg::pix_item_t s2_item, s3_item, s4_item;
  logic [WIN_W-1:0]  s2_q;
  logic [REM_W-1:0]  s3_rem;
  logic [ROW_W-1:0]  s3_row;
  logic              s4_ok;
  logic [ADDR_W-1:0] s4_row;
  logic [ADDR_W-1:0] s4_col;

  logic [PROD_W-1:0] q_prod;
  logic [REM_W-1:0]  rem_calc;
  logic [ROW_W-1:0]  row_calc;
  logic [COL_W-1:0]  col_calc;
  logic              ok_calc;
  logic [ADDR_W-1:0] addr_calc;

  assign ready5     = !out_valid || out_ready;
  assign ready4     = !v4 || ready5;
  assign ready3     = !v3 || ready4;
  assign ready2     = !v2 || ready3;
  assign item_ready = ready2;

  assign q_prod = PROD_W'(item.pos[WIN_W-1:0]) * PROD_W'(RECIP);

  assign rem_calc = REM_W'(s2_item.pos[WIN_W-1:0] - s2_q * WIN_W'(WINDOWS_PER_ROW));
  assign row_calc = ROW_W'(s2_q) * ROW_W'(WINDOW_HEIGHT) + ROW_W'(s2_item.wrow);

  assign col_calc = COL_W'(s3_rem) * COL_W'(WINDOW_WIDTH) + COL_W'(s3_item.wcol);
  assign ok_calc  = s3_item.have && (s3_item.linear
                  ? (32'(s3_item.pos) < 32'(FRAME_PIXELS))
                  : (32'(s3_row) < 32'(FRAME_ROWS) && 32'(col_calc) < 32'(FRAME_COLS)));

  // Only the low address bits are kept, so the row can be cut before the multiply
  assign addr_calc = s4_item.linear ? s4_item.pos[ADDR_W-1:0]
                   : s4_row * ADDR_W'(FRAME_COLS) + s4_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready2) begin
        v2 <= item_valid;
      end
      if (ready3) begin
        v3 <= v2;
      end
      if (ready4) begin
        v4 <= v3;
      end
      if (ready5) begin
        out_valid <= v4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready2) begin
      s2_item <= item;
      s2_q    <= q_prod[DIV_SHIFT +: WIN_W];
    end
    if (ready3) begin
      s3_item <= s2_item;
      s3_rem  <= rem_calc;
      s3_row  <= row_calc;
    end
    if (ready4) begin
      s4_item <= s3_item;
      s4_ok   <= ok_calc;
      s4_row  <= s3_row[ADDR_W-1:0];
      s4_col  <= col_calc[ADDR_W-1:0];
    end
    if (ready5) begin
      out_we     <= s4_ok;
      out_addr   <= s4_ok ? addr_calc : '0;
      out_red    <= s4_ok ? s4_item.red : 8'd0;
      out_green  <= s4_ok ? s4_item.green : 8'd0;
      out_blue   <= s4_ok ? s4_item.blue : 8'd0;
      out_status <= s4_item.status;
    end
  end

endmodule

`default_nettype wire

>>> rtl/pixel_datagram_unpacker.sv
// Display packet unpacker. Takes one packet byte per cycle on the s_ side while s_tready is
// high (tlast on the final byte) and gives exactly one result item per byte on the m_ side,
// in order, after five register stages, the first loaded by the edge that takes the byte.
// The result is a frame-store write (address and color, write flag in tuser) when the byte
// completes a pixel that lies inside the frame, and a packet status (frame ready, header
// error, short packet) in tuser. The header parser keeps all per-packet state and finishes
// each byte in the cycle it is taken, so a new byte is accepted every cycle while s_tready
// is high; the address is built over four more register stages (window divide, row/column,
// range check, final address). Input is held off only when all five stages are full and
// m_tready is low. Configuration registers are written through cfg_we/cfg_index/cfg_data
// and act on the next byte; write them only when no result is pending.
`default_nettype none

module pixel_datagram_unpacker #(
  parameter int WINDOWS_PER_ROW = pdu_pkg::WINDOWS_PER_ROW_DEF,
  parameter int WINDOW_ROWS     = pdu_pkg::WINDOW_ROWS_DEF,
  parameter int WINDOW_WIDTH    = pdu_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT   = pdu_pkg::WINDOW_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,   // data_byte
  input  wire logic                            s_tlast,   // last_byte
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [39:0]                          m_tdata,   // pixel_address, red, green, blue
  output logic [2:0]                           m_tuser,   // write_enable, packet_status
  input  wire logic                            cfg_we,
  input  wire logic [pdu_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [pdu_pkg::CFG_W-1:0]       cfg_data
);

  pdu_pkg::cfg_t      cfg;
  pdu_pkg::pix_item_t item;
  logic               item_valid;
  logic               item_ready;

  logic                        write_enable;
  logic [pdu_pkg::ADDR_W-1:0]  pixel_address;
  logic [7:0]                  red;
  logic [7:0]                  green;
  logic [7:0]                  blue;
  pdu_pkg::status_t            packet_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.packed_color       <= pdu_pkg::PACKED_COLOR_RST;
      cfg.low_nibble_shift   <= pdu_pkg::LOW_NIBBLE_SHIFT_RST;
      cfg.header_bytes       <= pdu_pkg::HEADER_BYTES_RST;
      cfg.packet_limit       <= pdu_pkg::PACKET_LIMIT_RST;
      cfg.pixels_per_packet  <= pdu_pkg::PIXELS_PER_PACKET_RST;
      cfg.windows_per_packet <= pdu_pkg::WINDOWS_PER_PACKET_RST;
      cfg.window_count       <= pdu_pkg::WINDOW_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pdu_pkg::CFG_PACKED_COLOR:       cfg.packed_color       <= cfg_data[0];
        pdu_pkg::CFG_LOW_NIBBLE_SHIFT:   cfg.low_nibble_shift   <= cfg_data[2:0];
        pdu_pkg::CFG_HEADER_BYTES:       cfg.header_bytes       <= cfg_data[3:0];
        pdu_pkg::CFG_PACKET_LIMIT:       cfg.packet_limit       <= cfg_data[7:0];
        pdu_pkg::CFG_PIXELS_PER_PACKET:  cfg.pixels_per_packet  <= cfg_data[9:0];
        pdu_pkg::CFG_WINDOWS_PER_PACKET: cfg.windows_per_packet <= cfg_data[7:0];
        pdu_pkg::CFG_WINDOW_COUNT:       cfg.window_count       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  pdu_parser #(
    .WINDOW_WIDTH  (WINDOW_WIDTH),
    .WINDOW_HEIGHT (WINDOW_HEIGHT)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .in_last    (s_tlast),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  pdu_addr #(
    .WINDOWS_PER_ROW (WINDOWS_PER_ROW),
    .WINDOW_ROWS     (WINDOW_ROWS),
    .WINDOW_WIDTH    (WINDOW_WIDTH),
    .WINDOW_HEIGHT   (WINDOW_HEIGHT)
  ) u_addr (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_we     (write_enable),
    .out_addr   (pixel_address),
    .out_red    (red),
    .out_green  (green),
    .out_blue   (blue),
    .out_status (packet_status)
  );

  assign m_tdata = {6'd0, blue, green, red, pixel_address};
  assign m_tuser = {packet_status, write_enable};

endmodule

`default_nettype wire

>>> rtl/pdu_checker.sv
`default_nettype none

module pdu_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [39:0]                   m_tdata,
  input wire logic [2:0]                    m_tuser
);

  logic [2:0] outstanding;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else begin
      outstanding <= outstanding + 3'(in_acc) - 3'(out_acc);
    end
  end

  // No result leaves the block without a byte behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> outstanding != 3'd0)
    else $error("result shown with no byte outstanding");

  // Bytes in flight never exceed the stages that can hold them
  a_depth: assert property (@(posedge clk) disable iff (rst)
    outstanding <= 3'(pdu_pkg::PIPE_DEPTH))
    else $error("more bytes in flight than pipeline stages");

  // A dropped or absent write carries zero address and color
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 40'd0)
    else $error("nonzero payload without write_enable");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind pixel_datagram_unpacker pdu_checker u_pdu_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
